// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication to the next cycle, off while in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication to the next cycle, checked in reset too.
`define ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/crc32ms_pkg.sv =====
package crc32ms_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CRC_W       = 32;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              last;
    logic [BYTE_W-1:0] data;
  } item_t;

  function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] byte_in);
    logic [CRC_W-1:0] crc;
    crc = crc_in ^ {byte_in, {(CRC_W-BYTE_W){1'b0}}};
    for (int k = 0; k < BYTE_W; k++) begin
      if (crc[CRC_W-1]) begin
        crc = {crc[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[CRC_W-2:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== sv/crc32_msb_first_stream_top.sv =====
// CRC-32/MPEG-2 over a byte stream, one word per message (on its last byte).
// Throughput: one byte per cycle while the output is not stalled; the byte fold in the back end is combinational.
// An accepted byte passes through the input stage and the queue, and the CRC of a
// message lands in the output register, where it is held while the output is stalled.
// Reset (rst, synchronous, active high) empties the queue and loads the CRC with all ones.
module crc32_msb_first_stream_top #(
  parameter int unsigned DEPTH = crc32ms_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [crc32ms_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                          s_tlast,    // last_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [crc32ms_pkg::CRC_W-1:0] m_tdata     // [31:0] crc_value
);
  import crc32ms_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  crc32ms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  crc32ms_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  crc32ms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== sv/crc32ms_front.sv =====
module crc32ms_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [crc32ms_pkg::BYTE_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  output logic                              push_valid,
  input  logic                              push_ready,
  output crc32ms_pkg::item_t                push_item
);
  import crc32ms_pkg::*;

  logic  stage_valid;
  item_t stage_item;

  assign s_tready   = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_item.data <= s_tdata;
      stage_item.last <= s_tlast;
    end
  end

endmodule

// ===== sv/crc32ms_queue.sv =====
module crc32ms_queue #(
  parameter int unsigned DEPTH = crc32ms_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  crc32ms_pkg::item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output crc32ms_pkg::item_t pop_item
);
  import crc32ms_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/crc32ms_back.sv =====
module crc32ms_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  crc32ms_pkg::item_t             pop_item,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [crc32ms_pkg::CRC_W-1:0]  m_tdata
);
  import crc32ms_pkg::*;

  logic [CRC_W-1:0] crc;
  logic [CRC_W-1:0] crc_next;
  logic             out_free;
  logic             do_pop;

  assign crc_next  = crc_fold_byte(crc, pop_item.data);
  assign out_free  = !m_tvalid || m_tready;
  // a last word needs room in the output register
  assign pop_ready = !pop_item.last || out_free;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_INIT;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (do_pop) begin
        if (pop_item.last) begin
          crc      <= CRC_INIT;
          m_tvalid <= 1'b1;
        end else begin
          crc <= crc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop && pop_item.last) begin
      m_tdata <= crc_next;
    end
  end

endmodule

// ===== sv/crc32ms_checker.sv =====
`include "assert_macros.svh"

module crc32ms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [crc32ms_pkg::BYTE_W-1:0] s_tdata,
  input logic                           s_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [crc32ms_pkg::CRC_W-1:0]  m_tdata
);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // no result straight out of reset
  `ASSERT_NEXT_ALWAYS(a_out_idle_after_rst, rst, !m_tvalid)
  // input stage empty after reset
  `ASSERT_NEXT_ALWAYS(a_ready_after_rst, rst, s_tready)

endmodule

bind crc32_msb_first_stream_top crc32ms_checker u_checker (.*);

// ===== sim/crc32_msb_first_stream_checker.sv =====
`timescale 1ns / 100ps

module crc32_msb_first_stream_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [crc32ms_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
  input  logic                           s_tlast,   // last_byte
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [crc32ms_pkg::CRC_W-1:0]  m_tdata,   // [31:0] crc_value
  output int                             mismatches,
  output int                             crc_pending
);

  logic [crc32ms_pkg::CRC_W-1:0] crc_accum;
  logic [crc32ms_pkg::CRC_W-1:0] crc_expected_q[$];

  // bit-serial LFSR form: feedback is msb xor incoming bit
  function automatic logic [crc32ms_pkg::CRC_W-1:0] fold_msb_first(
    input logic [crc32ms_pkg::CRC_W-1:0]  crc_now,
    input logic [crc32ms_pkg::BYTE_W-1:0] data_in
  );
    logic [crc32ms_pkg::CRC_W-1:0] acc;
    logic                          fb;
    acc = crc_now;
    for (int i = crc32ms_pkg::BYTE_W - 1; i >= 0; i--) begin
      fb  = acc[crc32ms_pkg::CRC_W-1] ^ data_in[i];
      acc = acc << 1;
      if (fb) begin
        acc = acc ^ crc32ms_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  initial begin
    mismatches  = 0;
    crc_pending = 0;
    crc_accum   = crc32ms_pkg::CRC_INIT;
  end

  always @(posedge clk) begin
    logic [crc32ms_pkg::CRC_W-1:0] next_crc;
    logic [crc32ms_pkg::CRC_W-1:0] want;
    if (rst) begin
      crc_accum = crc32ms_pkg::CRC_INIT;
    end else begin
      if (s_tvalid && s_tready) begin
        next_crc = fold_msb_first(crc_accum, s_tdata);
        if (s_tlast) begin
          crc_expected_q.push_back(next_crc);
          crc_accum = crc32ms_pkg::CRC_INIT;
        end else begin
          crc_accum = next_crc;
        end
      end
      if (m_tvalid && m_tready) begin
        if (crc_expected_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual crc_value=%08h",
                   $time, m_tdata);
          mismatches++;
        end else begin
          want = crc_expected_q.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                     $time, want, m_tdata);
            mismatches++;
          end
        end
      end
    end
    crc_pending = crc_expected_q.size();
  end

endmodule

// ===== sim/crc32_msb_first_stream_top_tb.sv =====
`timescale 1ns / 100ps

module crc32_msb_first_stream_top_tb;

  localparam int RANDOM_BYTES = 600;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [crc32ms_pkg::BYTE_W-1:0] s_tdata = '0;
  logic                           s_tlast = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [crc32ms_pkg::CRC_W-1:0]  m_tdata;

  int mismatches;
  int crc_pending;
  int bytes_sent = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  crc32_msb_first_stream_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  crc32_msb_first_stream_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .crc_pending (crc_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (idle_on) begin
      m_tready <= ($urandom_range(0, 99) >= 25);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [crc32ms_pkg::BYTE_W-1:0] b, input logic lst);
    if (idle_on && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lst;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
    idle_on = !(bytes_sent >= 250 && bytes_sent < 400);
  endtask

  task automatic send_message(input logic [crc32ms_pkg::BYTE_W-1:0] fill, input int len);
    for (int j = 0; j < len; j++) begin
      send_byte(fill, j == len - 1);
    end
  endtask

  initial begin
    logic [crc32ms_pkg::BYTE_W-1:0] b;
    int len;
    int start;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // one-byte messages at the field extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b1);
    // check string "123456789"
    for (int j = 0; j < 9; j++) begin
      send_byte(8'(8'h31 + j), j == 8);
    end
    send_message(8'hFF, 4);
    send_message(8'h00, 4);

    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      for (int j = 0; j < len; j++) begin
        case ($urandom_range(0, 7))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        send_byte(b, j == len - 1);
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    @(posedge clk);
    while (crc_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
